@@ design/brush_pattern_plotter_macros.svh @@
// Assertion macros for the brush pattern plotter top level.
`ifndef BRUSH_PATTERN_PLOTTER_MACROS_SVH
`define BRUSH_PATTERN_PLOTTER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BPP_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("brush pattern plotter: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define BPP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("brush pattern plotter: next-cycle check failed");

`endif

@@ design/bpp_pkg.sv @@
// Package with the types, screen constants and pattern tables of the brush plotter.
package bpp_pkg;

   localparam int unsigned SCREEN_WIDTH  = 160;
   localparam int unsigned SCREEN_HEIGHT = 168;

   localparam int unsigned CODE_SQUARE_BIT = 4;
   localparam int unsigned CODE_SPLAT_BIT  = 5;

   localparam logic [8:0] SCREEN_WIDTH_W  = 9'(SCREEN_WIDTH);
   localparam logic [8:0] SCREEN_HEIGHT_W = 9'(SCREEN_HEIGHT);
   localparam logic [8:0] NOISE_WRAP      = 9'd255;
   localparam logic [6:0] CIRCLE_LAST_BIT = 7'd119;

   typedef struct packed {
      logic [7:0] x_coord;
      logic [7:0] y_coord;
      logic [7:0] splatter_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] row_y;
      logic [7:0] row_x_start;
      logic [7:0] pixel_mask;
      logic       last_row;
   } rsp_type;

   typedef struct packed {
      logic [7:0] top;
      logic [7:0] x_start;
      logic [2:0] pen_size;
      logic       square;
      logic       splat;
      logic [7:0] noise_pos;
   } plot_ctx_type;

   // Circle bitmaps, one 120-bit word per pen size, point n at bit 119 - n.
   localparam logic [7:0][119:0] CIRCLE_BITS = {
      120'h183c7e7e7effffffffff7e7e7e3c18,
      {96'h38f9f3effffffffef9f3e380, 24'h0},
      {72'h31e79effffde79e300, 48'h0},
      {48'h23bfffffee20, 72'h0},
      {32'h66fff660, 88'h0},
      {16'h5ff4, 104'h0},
      {8'hfc, 112'h0},
      {8'h80, 112'h0}
   };

   // Noise map, position q at bit 255 - q.
   localparam logic [255:0] NOISE_MAP = {
      64'h209402249082a4a2, 64'h82090a2212104214,
      64'h914a911108122510, 64'h22a8142400502404
   };

   // Walk start positions, pattern index i at bits 1023 - 8i down to 1016 - 8i.
   localparam logic [1023:0] NOISE_START = {
      64'h001830c4dc65eb48, 64'h60bd89050af47d7d,
      64'h85b08e951f220ddf, 64'h2a78d5731cb440a1,
      64'hb93cca589234ccce, 64'hd742900f8b7f32ed,
      64'h5c9dc899ad4e56a6, 64'hf768b72582373a51,
      64'h692638529e9a4fa7, 64'h431080ee3d5935cf,
      64'h7974b5a2b19623e0, 64'hbe05f56e19c56649,
      64'hf0d154a9704ba4e2, 64'he6e5abe4d2aa4ce3,
      64'h066fc64aa47597e1, 64'h0000000000000000
   };

   function automatic logic [7:0] noise_start_pos(input logic [6:0] idx);
      logic [9:0] base;
      base = {3'd0, 7'(7'd127 - idx)} << 3;
      return NOISE_START[base +: 8];
   endfunction

endpackage

@@ design/bpp_item_load.sv @@
// Clamps the brush centre and derives the plot context of one accepted beat.
module bpp_item_load
   import bpp_pkg::*;
(
   input  req_type      req,
   input  logic [5:0]   brush_code,
   output plot_ctx_type ctx
);

   logic [2:0] pen;
   logic [8:0] x_lo;
   logic [8:0] x_hi;
   logic [8:0] y_lim;
   logic [8:0] x_w;
   logic [8:0] y_w;
   logic [8:0] x_clamped;
   logic [8:0] y_clamped;

   always_comb begin
      pen   = brush_code[2:0];
      x_lo  = 9'(pen >> 1) + 9'd1;
      x_hi  = SCREEN_WIDTH_W - x_lo;
      y_lim = SCREEN_HEIGHT_W - 9'(pen);
      x_w   = {1'b0, req.x_coord};
      y_w   = {1'b0, req.y_coord};

      if (x_w < x_lo) begin
         x_clamped = x_lo;
      end else if (x_w > x_hi) begin
         x_clamped = x_hi;
      end else begin
         x_clamped = x_w;
      end

      if (y_w < 9'(pen)) begin
         y_clamped = 9'(pen);
      end else if (y_w >= y_lim) begin
         y_clamped = y_lim - 9'd1;
      end else begin
         y_clamped = y_w;
      end

      ctx.top       = 8'(y_clamped - 9'(pen));
      ctx.x_start   = 8'(x_clamped - (9'(pen) + 9'd1) / 2);
      ctx.pen_size  = pen;
      ctx.square    = brush_code[CODE_SQUARE_BIT];
      ctx.splat     = brush_code[CODE_SPLAT_BIT];
      ctx.noise_pos = noise_start_pos(req.splatter_byte[7:1]);
   end

endmodule

@@ design/bpp_row_mask.sv @@
// Builds the pixel mask of one brush row and the noise position after it.
module bpp_row_mask
   import bpp_pkg::*;
(
   input  logic [2:0] pen_size,
   input  logic       square,
   input  logic       splat,
   input  logic [6:0] circle_pos,
   input  logic [7:0] noise_pos,
   output logic [7:0] pixel_mask,
   output logic [7:0] noise_pos_next
);

   logic [7:0] point;
   logic [3:0] count;
   logic [8:0] q;
   logic       in_shape;

   always_comb begin
      count      = 4'd0;
      pixel_mask = 8'd0;
      for (int c = 0; c < 8; c++) begin
         point    = {1'b0, circle_pos} + 8'(c);
         in_shape = (3'(c) <= pen_size) && (c <= 7) &&
                    (square || ((point <= {1'b0, CIRCLE_LAST_BIT}) &&
                                CIRCLE_BITS[pen_size][7'(CIRCLE_LAST_BIT - 7'(point))]));
         if (in_shape && splat) begin
            q = {1'b0, noise_pos} + 9'(count);
            if (q >= NOISE_WRAP) begin
               q = q - NOISE_WRAP;
            end
            pixel_mask[c] = NOISE_MAP[8'(NOISE_WRAP - q)];
            count = count + 4'd1;
         end else begin
            pixel_mask[c] = in_shape;
         end
      end
      q = {1'b0, noise_pos} + 9'(count);
      if (q >= NOISE_WRAP) begin
         q = q - NOISE_WRAP;
      end
      noise_pos_next = 8'(q);
   end

endmodule

@@ design/brush_pattern_plotter.sv @@
// Top level of the brush pattern plotter: row sequencer and result register.
//
// A brush plot is offered on req_data with start; it is taken at a clock edge
// where start is high and busy is low. The brush code is written through csr_we
// and csr_wdata while the block is idle, and applies to the plots that follow.
// Each plot gives 2p+1 result beats, p being the pen size, top row first; each
// beat sits on rsp_data for one cycle with rsp_valid high, and the final row of
// a plot carries last_row. The first row is formed from the plot context that
// is registered at acceptance and reaches rsp_data via the result register.
// The row sequencer makes one row per cycle. busy falls in the cycle the final
// row is being formed, so the next plot is taken then and its rows follow
// without a gap. The receiver cannot hold results off; no beat is ever
// delayed or dropped. Reset clears the brush code to zero, abandons any
// plot in progress and leaves no pending result.
module brush_pattern_plotter
   import bpp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  req_type    req_data,
   output logic       rsp_valid,
   output rsp_type    rsp_data,
   input  logic       csr_we,
   input  logic [5:0] csr_wdata
);

`include "brush_pattern_plotter_macros.svh"

   logic [5:0]   code_ff;
   logic         active_ff;
   logic         active_in;
   logic [3:0]   row_ff;
   logic [3:0]   row_in;
   logic [6:0]   cpos_ff;
   logic [6:0]   cpos_in;
   logic [7:0]   pos_ff;
   logic [7:0]   pos_in;
   plot_ctx_type ctx_ff;
   plot_ctx_type ctx_in;
   plot_ctx_type load_ctx;
   logic         rsp_valid_ff;
   rsp_type      rsp_ff;
   rsp_type      rsp_in;
   logic         last_row;
   logic         accept;
   logic [7:0]   row_mask;
   logic [7:0]   pos_next;

   bpp_item_load u_load (
      .req        (req_data),
      .brush_code (code_ff),
      .ctx        (load_ctx)
   );

   bpp_row_mask u_mask (
      .pen_size       (ctx_ff.pen_size),
      .square         (ctx_ff.square),
      .splat          (ctx_ff.splat),
      .circle_pos     (cpos_ff),
      .noise_pos      (pos_ff),
      .pixel_mask     (row_mask),
      .noise_pos_next (pos_next)
   );

   always_comb begin
      last_row = (row_ff == {ctx_ff.pen_size, 1'b0});
      busy     = active_ff && !last_row;
      accept   = start && !busy;

      active_in = active_ff;
      row_in    = row_ff;
      cpos_in   = cpos_ff;
      pos_in    = pos_ff;
      ctx_in    = ctx_ff;
      if (accept) begin
         active_in = 1'b1;
         row_in    = 4'd0;
         cpos_in   = 7'd0;
         pos_in    = load_ctx.noise_pos;
         ctx_in    = load_ctx;
      end else if (active_ff) begin
         active_in = !last_row;
         row_in    = row_ff + 4'd1;
         cpos_in   = cpos_ff + 7'(ctx_ff.pen_size) + 7'd1;
         pos_in    = pos_next;
      end

      rsp_in.row_y       = ctx_ff.top + 8'(row_ff);
      rsp_in.row_x_start = ctx_ff.x_start;
      rsp_in.pixel_mask  = row_mask;
      rsp_in.last_row    = last_row;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_ff      <= 6'd0;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            code_ff <= csr_wdata;
         end
         active_ff    <= active_in;
         rsp_valid_ff <= active_ff;
      end
      row_ff  <= row_in;
      cpos_ff <= cpos_in;
      pos_ff  <= pos_in;
      ctx_ff  <= ctx_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `BPP_ASSERT_NEXT(a_rows_contiguous, clock, reset, rsp_valid && !rsp_data.last_row, rsp_valid)
   `BPP_ASSERT_NEXT(a_row_y_steps, clock, reset, rsp_valid && !rsp_data.last_row, rsp_data.row_y == $past(rsp_data.row_y) + 8'd1)
   `BPP_ASSERT_NEXT(a_x_start_held, clock, reset, rsp_valid && !rsp_data.last_row, $stable(rsp_data.row_x_start))

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for the brush pattern plotter, predicting every row beat.
module tb
   import bpp_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned SCREEN_W = 160;
   localparam int unsigned SCREEN_H = 168;
   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned RANDOM_PHASES = 10;
   localparam int unsigned PLOTS_PER_PHASE = 9;

   localparam logic [5:0] CODE_SIZE_MASK = 6'h07;
   localparam logic [5:0] CODE_UNUSED = 6'h08;
   localparam logic [5:0] CODE_SQUARE = 6'h10;
   localparam logic [5:0] CODE_SPLATTER = 6'h20;

   // Circle shapes by pen size, point n of the box at index n.
   localparam logic [0:7][0:119] ROUND_MAPS = {
      {8'h80, 112'h0},
      {8'hfc, 112'h0},
      {16'h5ff4, 104'h0},
      {32'h66fff660, 88'h0},
      {48'h23bfffffee20, 72'h0},
      {72'h31e79effffde79e300, 48'h0},
      {96'h38f9f3effffffffef9f3e380, 24'h0},
      120'h183c7e7e7effffffffff7e7e7e3c18
   };

   localparam logic [0:255] NOISE_BITS = {
      64'h209402249082a4a2, 64'h82090a2212104214,
      64'h914a911108122510, 64'h22a8142400502404
   };

   localparam logic [0:127][7:0] WALK_START = {
      64'h001830c4dc65eb48, 64'h60bd89050af47d7d,
      64'h85b08e951f220ddf, 64'h2a78d5731cb440a1,
      64'hb93cca589234ccce, 64'hd742900f8b7f32ed,
      64'h5c9dc899ad4e56a6, 64'hf768b72582373a51,
      64'h692638529e9a4fa7, 64'h431080ee3d5935cf,
      64'h7974b5a2b19623e0, 64'hbe05f56e19c56649,
      64'hf0d154a9704ba4e2, 64'he6e5abe4d2aa4ce3,
      64'h066fc64aa47597e1, 64'h0000000000000000
   };

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   req_type    req_data;
   logic       rsp_valid;
   rsp_type    rsp_data;
   logic       csr_we;
   logic [5:0] csr_wdata;

   logic [5:0]  brush_code;
   rsp_type     expected_rows[$];
   int unsigned errors;
   int unsigned plots_sent;
   int unsigned rows_seen;
   int unsigned code_writes;
   int unsigned quiet_cycles;
   bit          gaps_on;

   brush_pattern_plotter u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   function automatic void predict_rows(input logic [5:0] code, input req_type item);
      int unsigned pen, lo, hi, cx, cy, walk, pt, top, xs;
      logic square, splat, hit;
      rsp_type row;
      pen = int'(code & CODE_SIZE_MASK);
      square = (code & CODE_SQUARE) != 0;
      splat = (code & CODE_SPLATTER) != 0;
      lo = pen / 2 + 1;
      hi = SCREEN_W - lo;
      cx = item.x_coord;
      cy = item.y_coord;
      if (cx < lo) cx = lo;
      else if (cx > hi) cx = hi;
      if (cy < pen) cy = pen;
      else if (cy >= SCREEN_H - pen) cy = SCREEN_H - 1 - pen;
      top = cy - pen;
      xs = cx - (pen + 1) / 2;
      walk = WALK_START[item.splatter_byte[7:1]];
      pt = 0;
      for (int r = 0; r <= 2 * pen; r++) begin
         row.row_y = 8'(top + r);
         row.row_x_start = 8'(xs);
         row.pixel_mask = '0;
         row.last_row = (r == 2 * pen);
         for (int c = 0; c <= pen; c++) begin
            hit = 1'b1;
            if (!square) begin
               hit = ROUND_MAPS[pen][pt];
               pt++;
            end
            if (hit && splat) begin
               hit = NOISE_BITS[walk];
               walk = (walk == 254) ? 0 : walk + 1;
            end
            if (hit) row.pixel_mask[c] = 1'b1;
         end
         expected_rows = {expected_rows, row};
      end
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (!gaps_on || roll < 40) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 95) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic [7:0] pick_field();
      logic [7:0] edges[6];
      edges = '{8'd0, 8'd1, 8'd238, 8'd239, 8'd254, 8'd255};
      if ($urandom_range(0, 7) == 0) return edges[$urandom_range(0, 5)];
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endfunction

   task automatic send_plot(input logic [7:0] x, input logic [7:0] y, input logic [7:0] sb);
      int unsigned gap;
      req_type item;
      item.x_coord = x;
      item.y_coord = y;
      item.splatter_byte = sb;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_rows(brush_code, item);
      plots_sent++;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      start <= 1'b0;
      while (expected_rows.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_brush_code(input logic [5:0] value);
      wait_idle();
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      brush_code = value;
      code_writes++;
   endtask

   task automatic test_reset_code();
      send_plot(8'd0, 8'd0, 8'd0);
      send_plot(8'd239, 8'd239, 8'd239);
   endtask

   task automatic test_square_clamping();
      write_brush_code(CODE_SQUARE | 6'd7);
      send_plot(8'd0, 8'd0, 8'd0);
      send_plot(8'd255, 8'd255, 8'd255);
      write_brush_code(CODE_SQUARE | CODE_UNUSED | 6'd6);
      send_plot(8'd159, 8'd167, 8'd0);
      send_plot(8'd4, 8'd6, 8'd0);
   endtask

   task automatic test_circle_sizes();
      for (int p = 0; p < 8; p++) begin
         write_brush_code(6'(p));
         send_plot(8'd80, 8'd84, 8'd0);
      end
   endtask

   task automatic test_splatter_walk();
      // Pattern 13 starts near the end of the noise map, so the walk wraps.
      write_brush_code(CODE_SPLATTER | CODE_SQUARE | 6'd7);
      send_plot(8'd100, 8'd100, 8'd26);
      send_plot(8'd50, 8'd60, 8'd239);
      send_plot(8'd50, 8'd60, 8'd240);
      send_plot(8'd50, 8'd60, 8'd255);
      write_brush_code(CODE_SPLATTER | 6'd7);
      send_plot(8'd120, 8'd20, 8'd1);
   endtask

   task automatic test_random_plots();
      logic [5:0] code;
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         if (ph == 0) code = 6'h3f;
         else if (ph == 1) code = 6'h00;
         else code = 6'($urandom_range(0, 63));
         gaps_on = (ph % 4) != 3;
         write_brush_code(code);
         for (int i = 0; i < PLOTS_PER_PHASE; i++)
            send_plot(pick_field(), pick_field(), pick_field());
      end
      gaps_on = 1'b1;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         rows_seen++;
         if (expected_rows.size() == 0) begin
            $display("%0t ns: unexpected row beat, expected none, actual %h", $time, rsp_data);
            errors++;
         end else begin
            want = expected_rows.pop_front();
            check_field("row_y", want.row_y, rsp_data.row_y);
            check_field("row_x_start", want.row_x_start, rsp_data.row_x_start);
            check_field("pixel_mask", want.pixel_mask, rsp_data.pixel_mask);
            check_field("last_row", 8'(want.last_row), 8'(rsp_data.last_row));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t ns: watchdog expired with %0d rows outstanding", $time,
                  expected_rows.size());
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_wdata = '0;
      brush_code = '0;
      errors = 0;
      plots_sent = 0;
      rows_seen = 0;
      code_writes = 0;
      quiet_cycles = 0;
      gaps_on = 1'b1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_code();
      test_square_clamping();
      test_circle_sizes();
      test_splatter_walk();
      test_random_plots();

      wait_idle();
      repeat (20) @(posedge clock);
      if (expected_rows.size() != 0) begin
         $display("%0t ns: %0d expected rows never arrived", $time, expected_rows.size());
         errors++;
      end
      $display("Ran %0d brush plots giving %0d row beats under %0d brush code writes,",
               plots_sent, rows_seen, code_writes);
      $display("covering every pen size, both shapes, both fills and screen-edge clamping.");
      if (errors == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end
endmodule

@@ files.f @@
+incdir+design
design/bpp_pkg.sv
design/bpp_item_load.sv
design/bpp_row_mask.sv
design/brush_pattern_plotter.sv
dv/tb.sv
